// ----- rtl/core/lu8d_pkg.sv -----
package lu8d_pkg;

  localparam int unsigned CODE_W = 31;
  localparam int unsigned MAX_ITEMS = 3;

  localparam logic [CODE_W-1:0] SUPP_BASE = 31'h0001_0000;
  localparam logic [CODE_W-1:0] SURR_HI = 31'h0000_D800;
  localparam logic [CODE_W-1:0] SURR_LO = 31'h0000_DC00;

  typedef struct packed {
    logic [1:0]                       count;
    logic                             term;
    logic [MAX_ITEMS-1:0][CODE_W-1:0] units;
  } bundle_t;

endpackage

// ----- rtl/core/lu8d_decode.sv -----
module lu8d_decode
  import lu8d_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  logic    utf16_mode,
  input  logic [7:0] byte_in,
  input  logic    last_byte,
  output bundle_t bundle
);

  logic [CODE_W-1:0] partial, partial_next;
  logic [2:0]        pending, pending_next;
  logic              ended, ended_next;
  logic [CODE_W-1:0] code;
  logic              have;
  logic [CODE_W-1:0] offset;

  assign offset = code - SUPP_BASE;

  always_comb begin
    partial_next = partial;
    pending_next = pending;
    ended_next   = ended;
    code         = '0;
    have         = 1'b0;
    bundle       = '0;

    if (pending == 3'd0) begin
      priority if (!byte_in[7]) begin
        code = {23'b0, byte_in};
        have = 1'b1;
      end else if (!byte_in[5]) begin
        partial_next = {26'b0, byte_in[4:0]};
        pending_next = 3'd1;
      end else if (!byte_in[4]) begin
        partial_next = {27'b0, byte_in[3:0]};
        pending_next = 3'd2;
      end else if (!byte_in[3]) begin
        partial_next = {28'b0, byte_in[2:0]};
        pending_next = 3'd3;
      end else if (!byte_in[2]) begin
        partial_next = {29'b0, byte_in[1:0]};
        pending_next = 3'd4;
      end else begin
        partial_next = {30'b0, byte_in[0]};
        pending_next = 3'd5;
      end
    end else begin
      partial_next = {partial[CODE_W-7:0], byte_in[5:0]};
      pending_next = pending - 3'd1;
      if (pending_next == 3'd0) begin
        code         = partial_next;
        have         = 1'b1;
        partial_next = '0;
      end
    end

    // cut short by end of string
    if (last_byte && pending_next != 3'd0) begin
      code         = '0;
      have         = 1'b1;
      partial_next = '0;
      pending_next = 3'd0;
    end

    if (have && !ended) begin
      if (code == '0) begin
        ended_next = 1'b1;
      end else if (utf16_mode && code >= SUPP_BASE) begin
        bundle.units[0] = SURR_HI | {21'b0, offset[19:10]};
        bundle.units[1] = SURR_LO | {21'b0, offset[9:0]};
        bundle.count    = 2'd2;
      end else begin
        bundle.units[0] = code;
        bundle.count    = 2'd1;
      end
    end

    if (last_byte) begin
      bundle.term  = 1'b1;
      bundle.count = bundle.count + 2'd1;
      partial_next = '0;
      pending_next = 3'd0;
      ended_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      pending <= 3'd0;
      ended   <= 1'b0;
    end else if (accept) begin
      partial <= partial_next;
      pending <= pending_next;
      ended   <= ended_next;
    end
  end

endmodule

// ----- rtl/core/lu8d_emit.sv -----
module lu8d_emit
  import lu8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bundle_t           bundle,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] code_unit,
  output logic              last_of_run,
  output logic              string_end
);

  logic [1:0]                       cnt;
  logic [1:0]                       idx;
  logic                             term;
  logic [MAX_ITEMS-1:0][CODE_W-1:0] units;
  logic                             take;

  assign out_valid   = cnt != 2'd0;
  assign take        = out_valid && !out_stall;
  assign room        = (cnt == 2'd0) || (cnt == 2'd1 && take);
  assign code_unit   = units[idx];
  assign last_of_run = cnt == 2'd1;
  assign string_end  = term && cnt == 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= bundle.count;
      idx <= 2'd0;
    end else if (take) begin
      cnt <= cnt - 2'd1;
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      term  <= bundle.term;
      units <= bundle.units;
    end
  end

endmodule

// ----- rtl/core/lenient_utf8_decoder.sv -----
// lenient utf-8 decoder, one byte per item on the input channel
// input: byte_in with last_byte on the final byte of a string, valid/stall
// output: code_unit items with last_of_run and string_end, valid/stall
// config: cfg_write with cfg_data sets utf16_mode (1 after reset); write only
// while idle
// each byte gives zero to three items: a code point or code unit, the two
// halves of a surrogate pair, and a closing item with string_end on the last
// byte. a zero code point ends the string and silences it up to the last byte
// the first item of a byte appears in the cycle after the byte is taken
// throughput: one byte per cycle while each byte gives at most one item and
// the receiver does not stall; a byte with more than one item holds the input
// until its items drain from the output register, which emits one at a time
// reset clears the decode state, empties the output register and sets utf16_mode
// when the receiver stalls, the held item stays and the input stalls once the
// pending items of the last byte cannot drain
module lenient_utf8_decoder
  import lu8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        byte_in,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] code_unit,
  output logic              last_of_run,
  output logic              string_end,
  input  logic              cfg_write,
  input  logic              cfg_data
);

  logic    utf16_mode;
  logic    room;
  logic    accept;
  bundle_t bundle;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      utf16_mode <= 1'b1;
    end else if (cfg_write) begin
      utf16_mode <= cfg_data;
    end
  end

  lu8d_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .utf16_mode (utf16_mode),
    .byte_in    (byte_in),
    .last_byte  (last_byte),
    .bundle     (bundle)
  );

  lu8d_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .bundle      (bundle),
    .room        (room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_unit   (code_unit),
    .last_of_run (last_of_run),
    .string_end  (string_end)
  );

  a_term_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> code_unit == '0 && last_of_run)
    else $error("closing item not zero or not last of run");

  a_unit_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !string_end |-> code_unit != '0)
    else $error("zero code unit outside closing item");

  a_last_gives_item: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> out_valid)
    else $error("last byte gave no closing item");

endmodule

// ----- tb/sv/lenient_utf8_decoder_test.sv -----
module lenient_utf8_decoder_test;
  import lu8d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;
  localparam int PLAN_LEN = 25;
  localparam int PHASE_ITEMS = 120;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              lor;
    logic              send;
  } unit_t;

  typedef struct packed {
    logic [7:0]        b;
    logic              l;
    logic              typed;
    logic              n;
    logic [CODE_W-1:0] code;
    logic              send;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        byte_in = 8'h00;
  logic              last_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CODE_W-1:0] code_unit;
  logic              last_of_run;
  logic              string_end;
  logic              cfg_write = 1'b0;
  logic              cfg_data = 1'b0;

  logic              utf16_on = 1'b1;
  logic [CODE_W-1:0] acc_code = '0;
  logic [2:0]        need_cnt = '0;
  logic              silenced = 1'b0;

  unit_t want_units[$];
  int    err_cnt = 0;
  int    cycle_cnt = 0;
  int    stall_left = 0;
  int    sent = 0;
  bit    calm = 1'b0;

  row_t plan [PLAN_LEN] = '{
    '{8'h41, 1'b0, 1'b1, 1'b1, 31'h41, 1'b0},
    '{8'h7F, 1'b0, 1'b1, 1'b1, 31'h7F, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 31'h0, 1'b0},
    '{8'h42, 1'b0, 1'b1, 1'b0, 31'h0, 1'b0},
    '{8'hC3, 1'b1, 1'b1, 1'b1, 31'h0, 1'b1},
    '{8'hC3, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hA9, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hE2, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'h82, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hAC, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'h9F, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'h98, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hFD, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hF8, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hE0, 1'b1, 1'b1, 1'b1, 31'h0, 1'b1},
    '{8'h80, 1'b0, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 31'h0, 1'b0}
  };

  lenient_utf8_decoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_in    (byte_in),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_unit  (code_unit),
    .last_of_run(last_of_run),
    .string_end (string_end),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // decodes one accepted byte, queues the units it gives when keep is set
  task automatic decode_byte(input logic [7:0] b, input logic l, input bit keep);
    logic              have;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] c;
    unit_t             outs[$];
    have = 1'b0;
    code = '0;
    if (need_cnt == 0) begin
      if (!b[7]) begin
        code = {23'b0, b};
        have = 1'b1;
      end else if (!b[5]) begin
        acc_code = {26'b0, b[4:0]};
        need_cnt = 3'd1;
      end else if (!b[4]) begin
        acc_code = {27'b0, b[3:0]};
        need_cnt = 3'd2;
      end else if (!b[3]) begin
        acc_code = {28'b0, b[2:0]};
        need_cnt = 3'd3;
      end else if (!b[2]) begin
        acc_code = {29'b0, b[1:0]};
        need_cnt = 3'd4;
      end else begin
        acc_code = {30'b0, b[0]};
        need_cnt = 3'd5;
      end
    end else begin
      acc_code = {acc_code[CODE_W-7:0], b[5:0]};
      need_cnt = need_cnt - 3'd1;
      if (need_cnt == 0) begin
        code = acc_code;
        have = 1'b1;
        acc_code = '0;
      end
    end
    if (l && need_cnt != 0) begin
      code = '0;
      have = 1'b1;
      acc_code = '0;
      need_cnt = '0;
    end
    if (have && !silenced) begin
      if (code == 0) begin
        silenced = 1'b1;
      end else if (utf16_on && code >= SUPP_BASE) begin
        c = code - SUPP_BASE;
        outs.push_back('{SURR_HI | ((c >> 10) & 31'h3FF), 1'b0, 1'b0});
        outs.push_back('{SURR_LO | (c & 31'h3FF), 1'b0, 1'b0});
      end else begin
        outs.push_back('{code, 1'b0, 1'b0});
      end
    end
    if (l) begin
      outs.push_back('{'0, 1'b0, 1'b1});
      acc_code = '0;
      need_cnt = '0;
      silenced = 1'b0;
    end
    if (outs.size() > 0) outs[outs.size()-1].lor = 1'b1;
    if (keep) begin
      foreach (outs[k]) want_units.push_back(outs[k]);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= b;
    last_byte <= l;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic feed(input logic [7:0] b, input logic l);
    send_byte(b, l);
    decode_byte(b, l, 1'b1);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (want_units.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_mode(input logic m);
    cfg_write <= 1'b1;
    cfg_data <= m;
    utf16_on = m;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // one code point as a byte sequence, sometimes noise, cut short or zero
  task automatic send_symbol();
    int         len;
    int         cut;
    int         r;
    bit         zero_cp;
    logic       endit;
    logic [7:0] seq[6];
    r = $urandom_range(0, 99);
    if (r < 10) begin
      feed(8'($urandom), $urandom_range(0, 7) == 0);
      return;
    end
    r = $urandom_range(0, 99);
    len = (r < 35) ? 1 : (r < 55) ? 2 : (r < 70) ? 3 : (r < 85) ? 4 : (r < 93) ? 5 : 6;
    zero_cp = $urandom_range(0, 29) == 0;
    case (len)
      1: seq[0] = {1'b0, 7'($urandom)};
      2: seq[0] = {3'b110, 5'($urandom)};
      3: seq[0] = {4'b1110, 4'($urandom)};
      4: seq[0] = {5'b11110, 3'($urandom)};
      5: seq[0] = {6'b111110, 2'($urandom)};
      default: seq[0] = {7'b1111110, 1'($urandom)};
    endcase
    if (zero_cp) seq[0] = (len == 1) ? 8'h00 : (seq[0] & ~(8'hFF >> (len + 1)));
    for (int k = 1; k < len; k++) begin
      if (zero_cp) seq[k] = 8'h80;
      else if ($urandom_range(0, 9) == 0) seq[k] = 8'($urandom);
      else seq[k] = {2'b10, 6'($urandom)};
    end
    endit = $urandom_range(0, 5) == 0;
    cut = len;
    if (len > 1 && $urandom_range(0, 19) == 0) begin
      cut = $urandom_range(1, len - 1);
      endit = 1'b1;
    end
    for (int k = 0; k < cut; k++) feed(seq[k], endit && k == cut - 1);
    if ($urandom_range(0, 149) == 0) drain();
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    unit_t w;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (want_units.size() == 0) begin
        if (err_cnt < 10)
          $display("unexpected item: code_unit %h last_of_run %b string_end %b",
                   code_unit, last_of_run, string_end);
        err_cnt <= err_cnt + 1;
      end else begin
        w = want_units.pop_front();
        if (code_unit !== w.code || last_of_run !== w.lor || string_end !== w.send) begin
          if (err_cnt < 10)
            $display("mismatch: want %h/%b/%b got %h/%b/%b", w.code, w.lor, w.send,
                     code_unit, last_of_run, string_end);
          err_cnt <= err_cnt + 1;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < PLAN_LEN; i++) begin
      send_byte(plan[i].b, plan[i].l);
      if (plan[i].typed) begin
        decode_byte(plan[i].b, plan[i].l, 1'b0);
        if (plan[i].n) want_units.push_back('{plan[i].code, 1'b1, plan[i].send});
      end else begin
        decode_byte(plan[i].b, plan[i].l, 1'b1);
      end
    end
    drain();
    for (int p = 0; p < 4; p++) begin
      set_mode(p[0]);
      calm = (p == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) send_symbol();
      drain();
    end
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- lenient_utf8_decoder.f -----
rtl/core/lu8d_pkg.sv
rtl/core/lu8d_decode.sv
rtl/core/lu8d_emit.sv
rtl/core/lenient_utf8_decoder.sv
tb/sv/lenient_utf8_decoder_test.sv
